>>> hdl/nsf_pkg.sv
// Shared types, constants and helpers for the sentence framer.
`default_nettype none
package nsf_pkg;

	localparam int HEADER_CHARS = 6;
	localparam int HDR_STORE    = 6;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [7:0] START_RESET = 8'd36;
	localparam logic [7:0] END_RESET   = 8'd42;
	localparam logic [7:0] COMMA_CHAR  = 8'd44;

	typedef enum logic [1:0] {
		CMD_OPEN   = 2'd0,
		CMD_CHAR   = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_ABORT  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_START  = 3'd0,
		REG_END    = 3'd1,
		REG_HDR    = 3'd2,
		REG_HLEN   = 3'd3,
		REG_EXPECT = 3'd4
	} reg_t;

	typedef struct packed {
		logic [7:0]  start_char;
		logic [7:0]  end_char;
		logic [47:0] header_bytes;
		logic [2:0]  header_length;
		logic [7:0]  expected_fields;
	} cfg_t;

	// One classified item handed from front to back.
	typedef struct packed {
		cmd_t       cmd;
		logic       hdr;
		logic [7:0] payload;
		logic [7:0] fields;
		logic       ready;
	} job_t;

	function automatic logic [2:0] eff_len(input logic [2:0] hl, input logic [2:0] lim);
		return (hl > lim) ? lim : hl;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v < 4'd10) ? (8'd48 + {4'd0, v}) : (8'd55 + {4'd0, v});
	endfunction

endpackage
`default_nettype wire

>>> hdl/nsf_front.sv
// Front end: tracks sentence state and classifies each input word into a job.
`default_nettype none
module nsf_front #(
	parameter int HEADER_CHARS = nsf_pkg::HEADER_CHARS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire nsf_pkg::cfg_t  cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire nsf_pkg::cmd_t  command,
	input  wire logic [7:0]     data_byte,
	output logic                push,
	output nsf_pkg::job_t       job,
	input  wire logic           push_ready
);

	localparam int HdrMax = (HEADER_CHARS < nsf_pkg::HDR_STORE) ?
		HEADER_CHARS : nsf_pkg::HDR_STORE;

	logic       open_q;
	logic [7:0] xor_q;
	logic [7:0] cnt_q;

	logic       nxt_open;
	logic [7:0] nxt_xor;
	logic [7:0] nxt_cnt;
	logic [7:0] base_xor;
	logic [7:0] base_cnt;
	logic [7:0] hdr_xor;
	logic [2:0] len;

	assign in_ready = push_ready;
	assign push     = in_valid & push_ready;
	assign len      = nsf_pkg::eff_len(cfg.header_length, 3'(HdrMax));

	always_comb begin
		hdr_xor = 8'd0;
		for (int i = 0; i < HdrMax; i++) begin
			if (3'(i) < len) begin
				hdr_xor = hdr_xor ^ cfg.header_bytes[8*i +: 8];
			end
		end
	end

	always_comb begin
		base_xor    = open_q ? xor_q : hdr_xor;
		base_cnt    = open_q ? cnt_q : 8'd0;
		nxt_open    = 1'b1;
		nxt_xor     = base_xor;
		nxt_cnt     = base_cnt;
		job.cmd     = command;
		job.hdr     = ~open_q & (command != nsf_pkg::CMD_ABORT);
		job.payload = 8'd0;
		unique case (command)
			nsf_pkg::CMD_OPEN: begin
				nxt_cnt     = base_cnt + 8'd1;
				nxt_xor     = base_xor ^ nsf_pkg::COMMA_CHAR;
				job.payload = nsf_pkg::COMMA_CHAR;
			end
			nsf_pkg::CMD_CHAR: begin
				nxt_xor     = base_xor ^ data_byte;
				job.payload = data_byte;
			end
			nsf_pkg::CMD_FINISH: begin
				// carry the checksum, then close the sentence
				job.payload = base_xor;
				nxt_open    = 1'b0;
				nxt_xor     = 8'd0;
				nxt_cnt     = 8'd0;
			end
			nsf_pkg::CMD_ABORT: begin
				nxt_open = 1'b0;
				nxt_xor  = 8'd0;
				nxt_cnt  = 8'd0;
			end
			default: begin
				nxt_open = open_q;
			end
		endcase
		job.fields = nxt_cnt;
		job.ready  = (nxt_cnt == cfg.expected_fields);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			xor_q  <= 8'd0;
			cnt_q  <= 8'd0;
		end else if (push) begin
			open_q <= nxt_open;
			xor_q  <= nxt_xor;
			cnt_q  <= nxt_cnt;
		end
	end

endmodule
`default_nettype wire

>>> hdl/nsf_queue.sv
// Short job queue between front and back ends.
`default_nettype none
module nsf_queue #(
	parameter int DEPTH = nsf_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire nsf_pkg::job_t push_data,
	output logic               push_ready,
	output logic               pop_valid,
	output nsf_pkg::job_t      pop_data,
	input  wire logic          pop_ready
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	nsf_pkg::job_t    mem_q [DEPTH];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [CntW-1:0]  cnt_q;
	logic             pop;

	assign push_ready = (cnt_q != CntW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/nsf_back.sv
// Back end: expands each job into sentence bytes, one byte per cycle while the output is not stalled.
`default_nettype none
module nsf_back #(
	parameter int HEADER_CHARS = nsf_pkg::HEADER_CHARS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire nsf_pkg::cfg_t cfg,
	input  wire logic          job_valid,
	input  wire nsf_pkg::job_t job_in,
	output logic               job_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic               sentence_done,
	output logic               aborted,
	output logic [7:0]         fields_so_far,
	output logic               fields_ready
);

	localparam int HdrMax = (HEADER_CHARS < nsf_pkg::HDR_STORE) ?
		HEADER_CHARS : nsf_pkg::HDR_STORE;
	localparam int IdxW = (HdrMax > 1) ? $clog2(HdrMax) : 1;

	typedef enum logic [2:0] {
		PH_START,
		PH_HDR,
		PH_BODY,
		PH_HEX_HI,
		PH_HEX_LO
	} phase_t;

	phase_t           phase_q;
	nsf_pkg::job_t    job_q;
	logic             busy_q;
	logic [IdxW-1:0]  idx_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             done_q;
	logic             abort_q;
	logic [7:0]       fields_q;
	logic             ready_q;

	logic [7:0]       hdr_arr [HdrMax];
	logic [2:0]       len;
	logic             out_free;
	logic             advance;
	logic [7:0]       e_byte;
	logic             e_last;
	logic             e_done;
	logic             e_abort;
	phase_t           nxt_phase;
	logic [IdxW-1:0]  nxt_idx;

	for (genvar g = 0; g < HdrMax; g++) begin : g_hdr
		assign hdr_arr[g] = cfg.header_bytes[8*g +: 8];
	end

	assign len       = nsf_pkg::eff_len(cfg.header_length, 3'(HdrMax));
	assign out_free  = ~valid_q | out_ready;
	assign advance   = out_free & busy_q;
	assign job_ready = ~busy_q | (advance & e_last);

	always_comb begin
		e_byte    = 8'd0;
		e_last    = 1'b0;
		e_done    = 1'b0;
		e_abort   = 1'b0;
		nxt_phase = phase_q;
		nxt_idx   = idx_q;
		unique case (phase_q)
			PH_START: begin
				e_byte    = cfg.start_char;
				nxt_phase = (len != 3'd0) ? PH_HDR : PH_BODY;
				nxt_idx   = '0;
			end
			PH_HDR: begin
				e_byte  = hdr_arr[idx_q];
				nxt_idx = idx_q + IdxW'(1);
				if (3'(idx_q) == len - 3'd1) begin
					nxt_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				unique case (job_q.cmd)
					nsf_pkg::CMD_FINISH: begin
						e_byte    = cfg.end_char;
						nxt_phase = PH_HEX_HI;
					end
					nsf_pkg::CMD_ABORT: begin
						e_byte  = 8'd0;
						e_abort = 1'b1;
						e_last  = 1'b1;
					end
					default: begin
						e_byte = job_q.payload;
						e_last = 1'b1;
					end
				endcase
			end
			PH_HEX_HI: begin
				e_byte    = nsf_pkg::hex_digit(job_q.payload[7:4]);
				nxt_phase = PH_HEX_LO;
			end
			PH_HEX_LO: begin
				e_byte = nsf_pkg::hex_digit(job_q.payload[3:0]);
				e_done = 1'b1;
				e_last = 1'b1;
			end
			default: begin
				nxt_phase = PH_BODY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BODY;
			busy_q   <= 1'b0;
			idx_q    <= '0;
			valid_q  <= 1'b0;
			job_q    <= '0;
			byte_q   <= 8'd0;
			last_q   <= 1'b0;
			done_q   <= 1'b0;
			abort_q  <= 1'b0;
			fields_q <= 8'd0;
			ready_q  <= 1'b0;
		end else begin
			if (out_free) begin
				valid_q <= busy_q;
			end
			if (advance) begin
				byte_q   <= e_byte;
				last_q   <= e_last;
				done_q   <= e_done;
				abort_q  <= e_abort;
				fields_q <= job_q.fields;
				ready_q  <= job_q.ready;
			end
			// take the next job, possibly in the cycle the current one ends
			if (job_valid && job_ready) begin
				job_q   <= job_in;
				busy_q  <= 1'b1;
				phase_q <= job_in.hdr ? PH_START : PH_BODY;
				idx_q   <= '0;
			end else if (advance) begin
				phase_q <= nxt_phase;
				idx_q   <= nxt_idx;
				if (e_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign last          = last_q;
	assign sentence_done = done_q;
	assign aborted       = abort_q;
	assign fields_so_far = fields_q;
	assign fields_ready  = ready_q;

endmodule
`default_nettype wire

>>> hdl/nmea_sentence_framer_unit.sv
// Sentence framer top level: register port, front end, job queue and back end.
// An accepted item is queued, loaded as the back end's job, then registered out.
// Throughput: one input word per cycle while the job queue has room; the back end
// sends one byte per cycle while not stalled: the payload, or end char and two hex
// checksum digits; a sentence's first item is preceded by start char and header.
// Reset: arst_n clears sentence state, queue and output; registers take defaults.
`default_nettype none
module nmea_sentence_framer_unit #(
	parameter int HEADER_CHARS = nsf_pkg::HEADER_CHARS,
	parameter int QUEUE_DEPTH  = nsf_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // command[1:0], data_byte[9:2], zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // out_byte[7:0], fields_so_far[15:8],
	                                         // fields_ready[16], zero
	output logic             m_axis_tlast,
	output logic [1:0]       m_axis_tuser    // sentence_done[0], aborted[1]
);

	nsf_pkg::cfg_t  cfg_q;
	nsf_pkg::reg_t  reg_sel;
	nsf_pkg::job_t  push_job;
	nsf_pkg::job_t  pop_job;
	logic           push;
	logic           push_ready;
	logic           pop_valid;
	logic           pop_ready;
	logic           wr_en;
	logic [7:0]     out_byte;
	logic [7:0]     fields_so_far;
	logic           fields_ready;
	logic           sentence_done;
	logic           aborted;

	assign pready  = 1'b1;
	assign reg_sel = nsf_pkg::reg_t'(paddr[5:3]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_char      <= nsf_pkg::START_RESET;
			cfg_q.end_char        <= nsf_pkg::END_RESET;
			cfg_q.header_bytes    <= 48'd0;
			cfg_q.header_length   <= 3'd0;
			cfg_q.expected_fields <= 8'd0;
		end else if (wr_en) begin
			unique case (reg_sel)
				nsf_pkg::REG_START:  cfg_q.start_char      <= pwdata[7:0];
				nsf_pkg::REG_END:    cfg_q.end_char        <= pwdata[7:0];
				nsf_pkg::REG_HDR:    cfg_q.header_bytes    <= pwdata[47:0];
				nsf_pkg::REG_HLEN:   cfg_q.header_length   <= pwdata[2:0];
				nsf_pkg::REG_EXPECT: cfg_q.expected_fields <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			nsf_pkg::REG_START:  prdata = {56'd0, cfg_q.start_char};
			nsf_pkg::REG_END:    prdata = {56'd0, cfg_q.end_char};
			nsf_pkg::REG_HDR:    prdata = {16'd0, cfg_q.header_bytes};
			nsf_pkg::REG_HLEN:   prdata = {61'd0, cfg_q.header_length};
			nsf_pkg::REG_EXPECT: prdata = {56'd0, cfg_q.expected_fields};
			default:             prdata = 64'd0;
		endcase
	end

	nsf_front #(
		.HEADER_CHARS(HEADER_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.command    (nsf_pkg::cmd_t'(s_axis_tdata[1:0])),
		.data_byte  (s_axis_tdata[9:2]),
		.push       (push),
		.job        (push_job),
		.push_ready (push_ready)
	);

	nsf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_job),
		.pop_ready  (pop_ready)
	);

	nsf_back #(
		.HEADER_CHARS(HEADER_CHARS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.job_valid     (pop_valid),
		.job_in        (pop_job),
		.job_ready     (pop_ready),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_byte      (out_byte),
		.last          (m_axis_tlast),
		.sentence_done (sentence_done),
		.aborted       (aborted),
		.fields_so_far (fields_so_far),
		.fields_ready  (fields_ready)
	);

	assign m_axis_tdata = {7'd0, fields_ready, fields_so_far, out_byte};
	assign m_axis_tuser = {aborted, sentence_done};

endmodule
`default_nettype wire
